FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suspended while reset is high
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fwcalu check failed");

// clocked check that also runs through reset
`define CHK_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("fwcalu check failed");

`endif

FILE: sv/fwcalu_pkg.sv
package fwcalu_pkg;

   localparam int DATA_W       = 64;
   localparam int WIDTH_W      = 7;
   localparam int MAX_BITS_DEF = 64;
   localparam int MODE_W       = 5;
   localparam int REQ_W        = 136;
   localparam int RSP_W        = 136;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd32;

   localparam logic [MODE_W-1:0] MODE_ADD   = 5'd0;
   localparam logic [MODE_W-1:0] MODE_SUB   = 5'd1;
   localparam logic [MODE_W-1:0] MODE_MUL   = 5'd2;
   localparam logic [MODE_W-1:0] MODE_DIV   = 5'd3;
   localparam logic [MODE_W-1:0] MODE_MOD   = 5'd4;
   localparam logic [MODE_W-1:0] MODE_NEG   = 5'd5;
   localparam logic [MODE_W-1:0] MODE_ADDU  = 5'd6;
   localparam logic [MODE_W-1:0] MODE_SUBU  = 5'd7;
   localparam logic [MODE_W-1:0] MODE_MULU  = 5'd8;
   localparam logic [MODE_W-1:0] MODE_DIVU  = 5'd9;
   localparam logic [MODE_W-1:0] MODE_MODU  = 5'd10;
   localparam logic [MODE_W-1:0] MODE_MUL2U = 5'd11;
   localparam logic [MODE_W-1:0] MODE_MUL2  = 5'd12;
   localparam logic [MODE_W-1:0] MODE_CMP   = 5'd13;
   localparam logic [MODE_W-1:0] MODE_CMPU  = 5'd14;
   localparam logic [MODE_W-1:0] MODE_AND   = 5'd15;
   localparam logic [MODE_W-1:0] MODE_OR    = 5'd16;
   localparam logic [MODE_W-1:0] MODE_XOR   = 5'd17;
   localparam logic [MODE_W-1:0] MODE_NOT   = 5'd18;
   localparam logic [MODE_W-1:0] MODE_LSH   = 5'd19;
   localparam logic [MODE_W-1:0] MODE_RSH   = 5'd20;
   localparam logic [MODE_W-1:0] MODE_ASH   = 5'd21;
   localparam logic [MODE_W-1:0] MODE_CVT   = 5'd22;
   localparam logic [MODE_W-1:0] MODE_CVTU  = 5'd23;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIVZ = 2'd2;

   localparam logic [1:0] CMP_EQ = 2'b00;
   localparam logic [1:0] CMP_GT = 2'b01;
   localparam logic [1:0] CMP_LT = 2'b11;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [WIDTH_W-1:0] n;
      logic [WIDTH_W-1:0] tw;
      logic [DATA_W-1:0]  m;
      logic [DATA_W-1:0]  a;
      logic [DATA_W-1:0]  b;
      logic [DATA_W-1:0]  ua;
      logic [DATA_W-1:0]  ub;
      logic               sa;
      logic               sb;
      logic [DATA_W-1:0]  dvd;
      logic [DATA_W-1:0]  dvs;
      logic [DATA_W-1:0]  quo;
      logic [DATA_W-1:0]  rem;
      logic [DATA_W-1:0]  p00;
      logic [DATA_W-1:0]  p01;
      logic [DATA_W-1:0]  p10;
      logic [DATA_W-1:0]  p11;
      logic [33:0]        mid;
      logic [2*DATA_W-1:0] prod;
      logic [DATA_W-1:0]  rl;
      logic [DATA_W-1:0]  rh;
      logic [1:0]         cmp;
      logic [1:0]         st;
   } stage_type;

   function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w,
                                                      input logic [WIDTH_W-1:0] hi);
      if (w < 7'd2) return 7'd2;
      if (w > hi) return hi;
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] mask_of(input logic [WIDTH_W-1:0] w);
      if (w >= 7'd64) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

endpackage

FILE: sv/fwcalu_stage.sv
module fwcalu_stage import fwcalu_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF,
   parameter int IDX      = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   localparam int K = (IDX >= 1 && IDX <= MAX_BITS) ? MAX_BITS - IDX : 0;
   localparam logic [WIDTH_W-1:0] MAXW = WIDTH_W'(MAX_BITS);

   logic      v_ff;
   stage_type d_ff;
   stage_type d_in;

   logic [WIDTH_W-1:0]  nn, tt;
   logic [DATA_W-1:0]   mm, aa, bb, sbit, x, y, sum, diff, neg, ext, tm, hmask, lim, q, r;
   logic                sgn, sdiff, big_sh, narrow;
   logic [64:0]         trial;
   logic [2*DATA_W-1:0] neg128;

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = d_ff;

   always_comb begin
      d_in   = in_data;
      nn     = clamp_width(in_data.n, MAXW);
      tt     = clamp_width(in_data.tw, MAXW);
      mm     = mask_of(nn);
      aa     = in_data.a & mm;
      bb     = in_data.b & mm;
      sbit   = 64'd1 << (in_data.n - 7'd1);
      sgn    = in_data.mode == MODE_MUL || in_data.mode == MODE_MUL2;
      x      = sgn ? in_data.ua : in_data.a;
      y      = sgn ? in_data.ub : in_data.b;
      sum    = (in_data.a + in_data.b) & in_data.m;
      diff   = (in_data.a - in_data.b) & in_data.m;
      neg    = (64'd0 - in_data.a) & in_data.m;
      ext    = in_data.sa ? (in_data.a | ~in_data.m) : in_data.a;
      tm     = mask_of(in_data.tw);
      hmask  = ~(tm >> 1);
      narrow = in_data.tw < in_data.n;
      big_sh = in_data.b >= {57'd0, in_data.n};
      sdiff  = in_data.sa != in_data.sb;
      lim    = sdiff ? sbit : sbit - 64'd1;
      q      = in_data.quo;
      r      = in_data.rem;
      trial  = {in_data.rem, in_data.dvd[K]};
      neg128 = ~in_data.prod + 128'd1;

      if (IDX == 0) begin
         d_in.n  = nn;
         d_in.tw = tt;
         d_in.m  = mm;
         d_in.a  = aa;
         d_in.b  = bb;
         d_in.sa = |(aa & (64'd1 << (nn - 7'd1)));
         d_in.sb = |(bb & (64'd1 << (nn - 7'd1)));
         d_in.ua = d_in.sa ? ((64'd0 - aa) & mm) : aa;
         d_in.ub = d_in.sb ? ((64'd0 - bb) & mm) : bb;
         d_in.dvd = (in_data.mode == MODE_DIV || in_data.mode == MODE_MOD) ? d_in.ua : aa;
         d_in.dvs = (in_data.mode == MODE_DIV || in_data.mode == MODE_MOD) ? d_in.ub : bb;
         d_in.quo = '0;
         d_in.rem = '0;
         d_in.rl  = '0;
         d_in.rh  = '0;
         d_in.cmp = CMP_EQ;
         d_in.st  = ST_OK;
      end

      if (IDX == 1) begin
         d_in.p00 = {32'd0, x[31:0]}  * {32'd0, y[31:0]};
         d_in.p01 = {32'd0, x[31:0]}  * {32'd0, y[63:32]};
         d_in.p10 = {32'd0, x[63:32]} * {32'd0, y[31:0]};
         d_in.p11 = {32'd0, x[63:32]} * {32'd0, y[63:32]};
         unique case (in_data.mode)
            MODE_ADD: begin
               d_in.rl = sum;
               if (!sdiff && ((|(sum & sbit)) != in_data.sa)) d_in.st = ST_OVF;
            end
            MODE_SUB: begin
               d_in.rl = diff;
               if (sdiff && ((|(diff & sbit)) != in_data.sa)) d_in.st = ST_OVF;
            end
            MODE_NEG: begin
               d_in.rl = neg;
               if (in_data.a == sbit) d_in.st = ST_OVF;
            end
            MODE_ADDU: begin
               d_in.rl = sum;
               if (sum < in_data.a) d_in.st = ST_OVF;
            end
            MODE_SUBU: begin
               d_in.rl = diff;
               if (in_data.a < in_data.b) d_in.st = ST_OVF;
            end
            MODE_CMP: begin
               if (sdiff) d_in.cmp = in_data.sa ? CMP_LT : CMP_GT;
               else if (in_data.a < in_data.b) d_in.cmp = CMP_LT;
               else if (in_data.a > in_data.b) d_in.cmp = CMP_GT;
               else d_in.cmp = CMP_EQ;
            end
            MODE_CMPU: begin
               if (in_data.a < in_data.b) d_in.cmp = CMP_LT;
               else if (in_data.a > in_data.b) d_in.cmp = CMP_GT;
               else d_in.cmp = CMP_EQ;
            end
            MODE_AND: d_in.rl = in_data.a & in_data.b;
            MODE_OR:  d_in.rl = in_data.a | in_data.b;
            MODE_XOR: d_in.rl = in_data.a ^ in_data.b;
            MODE_NOT: d_in.rl = ~in_data.a & in_data.m;
            MODE_LSH: d_in.rl = big_sh ? '0 : ((in_data.a << in_data.b[5:0]) & in_data.m);
            MODE_RSH: d_in.rl = big_sh ? '0 : (in_data.a >> in_data.b[5:0]);
            MODE_ASH: begin
               if (big_sh) d_in.rl = in_data.sa ? in_data.m : '0;
               else d_in.rl = 64'($signed(ext) >>> in_data.b[5:0]) & in_data.m;
            end
            MODE_CVT: begin
               if (narrow && (in_data.a & hmask) != '0
                   && (in_data.a & hmask) != (in_data.m & hmask)) d_in.st = ST_OVF;
               d_in.rl = ext & tm;
            end
            MODE_CVTU: begin
               if (narrow && (in_data.a & ~tm) != '0) d_in.st = ST_OVF;
               d_in.rl = in_data.a & tm;
            end
            default: ;
         endcase
      end

      if (IDX == 2) begin
         d_in.mid = 34'(in_data.p00[63:32]) + 34'(in_data.p01[31:0])
                  + 34'(in_data.p10[31:0]);
      end

      if (IDX == 3) begin
         d_in.prod = {in_data.p11 + {32'd0, in_data.p01[63:32]}
                      + {32'd0, in_data.p10[63:32]} + {62'd0, in_data.mid[33:32]},
                      in_data.mid[31:0], in_data.p00[31:0]};
      end

      // restoring divider, one quotient bit per stage
      if (IDX >= 1 && IDX <= MAX_BITS) begin
         if (trial >= {1'b0, in_data.dvs}) begin
            d_in.rem    = 64'(trial - {1'b0, in_data.dvs});
            d_in.quo[K] = 1'b1;
         end else begin
            d_in.rem = trial[63:0];
         end
      end

      if (IDX == MAX_BITS + 1) begin
         unique case (in_data.mode)
            MODE_MUL: begin
               d_in.rl = sdiff ? ((64'd0 - in_data.prod[63:0]) & in_data.m)
                               : (in_data.prod[63:0] & in_data.m);
               if (in_data.prod[127:64] != '0 || in_data.prod[63:0] > lim) d_in.st = ST_OVF;
            end
            MODE_MULU: begin
               d_in.rl = in_data.prod[63:0] & in_data.m;
               if (in_data.prod[127:64] != '0 || in_data.prod[63:0] > in_data.m)
                  d_in.st = ST_OVF;
            end
            MODE_MUL2U: d_in.rl = in_data.prod[63:0] & in_data.m;
            MODE_MUL2: begin
               if (sdiff) d_in.prod = neg128;
               d_in.rl = (sdiff ? neg128[63:0] : in_data.prod[63:0]) & in_data.m;
            end
            MODE_DIV: begin
               if (in_data.b == '0) begin
                  d_in.rl = '0;
                  d_in.st = ST_DIVZ;
               end else if (sdiff) begin
                  d_in.rl = (r != '0 ? ~q : (64'd0 - q)) & in_data.m;
               end else begin
                  d_in.rl = q & in_data.m;
                  if (in_data.sa && (q & in_data.m & sbit) != '0) d_in.st = ST_OVF;
               end
            end
            MODE_MOD: begin
               if (in_data.b == '0) begin
                  d_in.rl = '0;
                  d_in.st = ST_DIVZ;
               end else if (!sdiff) begin
                  if (in_data.sa && (q & sbit) != '0) begin
                     d_in.rl = '0;
                     d_in.st = ST_OVF;
                  end else begin
                     d_in.rl = in_data.sa ? ((64'd0 - r) & in_data.m) : r;
                  end
               end else if (r == '0) begin
                  d_in.rl = '0;
               end else begin
                  d_in.rl = in_data.sb ? ((r - in_data.ub) & in_data.m) : (in_data.ub - r);
               end
            end
            MODE_DIVU, MODE_MODU: begin
               if (in_data.b == '0) begin
                  d_in.rl = '0;
                  d_in.st = ST_DIVZ;
               end else begin
                  d_in.rl = (in_data.mode == MODE_DIVU) ? q : r;
               end
            end
            default: ;
         endcase
      end

      if (IDX == MAX_BITS + 2) begin
         if (in_data.mode == MODE_MUL2U || in_data.mode == MODE_MUL2)
            d_in.rh = (in_data.n == 7'd64) ? in_data.prod[127:64]
                    : (64'(in_data.prod >> in_data.n) & in_data.m);
         else
            d_in.rh = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         d_ff <= d_in;
      end
   end

endmodule

FILE: sv/fixed_width_checked_integer_alu.sv
// Integer ALU with a programmable operand width (csr_data, clamped to 2..MAX_BITS, reset 32).
// Fully pipelined: one beat per cycle in and out while rsp_tready is high, pipeline depth set by the
// restoring divider that resolves one quotient bit per stage; the 64x64 multiply is split
// into four 32x32 products over three stages. Each stage holds its beat until the next
// stage has room, so bubbles collapse under backpressure. Write the width only while idle.
module fixed_width_checked_integer_alu import fwcalu_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,  // operand_a, operand_b, target_width, zero pad
   input  logic [MODE_W-1:0]  req_tuser,  // mode
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,  // result_low, result_high, compare_result, status, pad
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [WIDTH_W-1:0] csr_data
);

   localparam int L = MAX_BITS + 3;

   logic [WIDTH_W-1:0] width_ff;
   stage_type          raw;
   stage_type          pipe_data  [L];
   logic               pipe_valid [L];
   logic               pipe_ready [L];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid) begin
         width_ff <= csr_data;
      end
   end

   always_comb begin
      raw      = '0;
      raw.mode = req_tuser;
      raw.a    = req_tdata[63:0];
      raw.b    = req_tdata[127:64];
      raw.tw   = req_tdata[134:128];
      raw.n    = width_ff;
   end

   for (genvar i = 0; i < L; i++) begin : g_stage
      fwcalu_stage #(
         .MAX_BITS(MAX_BITS),
         .IDX     (i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid ((i == 0) ? req_tvalid : pipe_valid[(i == 0) ? 0 : i - 1]),
         .in_ready (pipe_ready[i]),
         .in_data  ((i == 0) ? raw : pipe_data[(i == 0) ? 0 : i - 1]),
         .out_valid(pipe_valid[i]),
         .out_ready((i == L - 1) ? rsp_tready : pipe_ready[(i == L - 1) ? i : i + 1]),
         .out_data (pipe_data[i])
      );
   end

   assign req_tready = pipe_ready[0];
   assign rsp_tvalid = pipe_valid[L-1];
   assign rsp_tdata  = {4'd0, pipe_data[L-1].st, pipe_data[L-1].cmp,
                        pipe_data[L-1].rh, pipe_data[L-1].rl};

endmodule

FILE: sv/fwcalu_checker.sv
`include "assert_macros.svh"

module fwcalu_props import fwcalu_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `CHK_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `CHK_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> rsp_tdata[131:130] != 2'b11)
   `CHK_ASSERT(a_cmp_alone, clock, reset, rsp_tvalid && rsp_tdata[129:128] != CMP_EQ |-> rsp_tdata[129:128] != 2'b10 && rsp_tdata[127:0] == '0 && rsp_tdata[131:130] == ST_OK)

endmodule

bind fixed_width_checked_integer_alu fwcalu_props u_fwcalu_props (.*);
